@@ sv/tcp_seq_ack_flow_adjust_unit_defines.svh @@
// Assertion macros shared by the flow adjustment unit.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef TCP_SEQ_ACK_FLOW_ADJUST_UNIT_DEFINES_SVH
`define TCP_SEQ_ACK_FLOW_ADJUST_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSAF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSAF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/tsaf_pkg.sv @@
// Package for the TCP sequence and acknowledgement flow adjustment unit.
// Holds the flow entry types and shared constants; depends on nothing.
package tsaf_pkg;

    localparam int FLOW_ENTRIES_DEF = 64;
    localparam int DPM_W            = 12;
    localparam int MCNT_W           = 11;
    localparam logic [7:0] PROTO_TCP = 8'd6;

    typedef struct packed {
        logic [63:0] addrs;
        logic [39:0] ports;
        logic [31:0] delta;
    } t_flow_entry;

    typedef struct packed {
        logic        we;
        t_flow_entry data;
    } t_mem_wr;

endpackage

@@ sv/tsaf_flow_mem.sv @@
// Flow table memory: one write port and one read port with registered read data.
// Depends on tsaf_pkg for the entry type.
module tsaf_flow_mem
    import tsaf_pkg::*;
#(
    parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF,
    localparam int IdxW = $clog2(FLOW_ENTRIES)
) (
    input  logic            i_clk,
    input  t_mem_wr         i_wr,
    input  logic [IdxW-1:0] i_waddr,
    input  logic [IdxW-1:0] i_raddr,
    output t_flow_entry     o_rdata
);

    t_flow_entry r_mem [FLOW_ENTRIES];
    t_flow_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_waddr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/tsaf_engine.sv @@
// Walk, compare and update engine: for a TCP header, scans the filled part of the
// flow table, then adjusts the header and writes or adds the own flow entry.
// Depends on tsaf_pkg and on the assertion macros header.
`include "tcp_seq_ack_flow_adjust_unit_defines.svh"

module tsaf_engine
    import tsaf_pkg::*;
#(
    parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF,
    localparam int IdxW = $clog2(FLOW_ENTRIES),
    localparam int CntW = $clog2(FLOW_ENTRIES + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [31:0]             i_src_addr,
    input  logic [15:0]             i_src_port,
    input  logic [31:0]             i_dst_addr,
    input  logic [15:0]             i_dst_port,
    input  logic [7:0]              i_protocol,
    input  logic [31:0]             i_seq_num,
    input  logic [31:0]             i_ack_num,
    input  logic [15:0]             i_ip_total_length,
    input  logic [MCNT_W-1:0]       i_match_count,
    input  logic signed [DPM_W-1:0] i_delta_per_match,
    output logic                    o_valid,
    output logic [31:0]             o_new_seq_num,
    output logic [31:0]             o_new_ack_num,
    output logic [15:0]             o_new_ip_length,
    output logic                    o_header_changed,
    output logic                    o_table_full,
    output logic [IdxW-1:0]         o_raddr,
    input  t_flow_entry             i_rdata,
    output t_mem_wr                 o_wr,
    output logic [IdxW-1:0]         o_waddr
);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_UPD} t_state;

    localparam logic [CntW-1:0] FullCount = CntW'(FLOW_ENTRIES);

    t_state              r_state;
    logic [CntW-1:0]     r_addr;
    logic                r_pend;
    logic [IdxW-1:0]     r_pend_idx;
    logic [CntW-1:0]     r_count;
    logic [63:0]         r_fa;
    logic [39:0]         r_fp;
    logic [31:0]         r_seq;
    logic [31:0]         r_ack;
    logic [15:0]         r_len;
    logic                r_mcnt_nz;
    logic                r_tcp;
    logic [31:0]         r_add;
    logic                r_own_hit;
    logic [IdxW-1:0]     r_own_idx;
    logic [31:0]         r_own_delta;
    logic                r_rev_hit;
    logic [31:0]         r_rev_delta;
    logic                r_valid;
    logic [31:0]         r_new_seq;
    logic [31:0]         r_new_ack;
    logic [15:0]         r_new_len;
    logic                r_changed;
    logic                r_full;

    logic                accept;
    logic [63:0]         rev_fa;
    logic [39:0]         rev_fp;
    logic                own_match;
    logic                rev_match;
    logic signed [23:0]  prod;
    logic                room;
    logic                upd_active;
    logic [31:0]         n_seq;
    logic [31:0]         n_ack;
    logic [15:0]         n_len;
    logic                n_changed;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    assign rev_fa    = {r_fa[31:0], r_fa[63:32]};
    assign rev_fp    = {r_fp[23:8], r_fp[39:24], r_fp[7:0]};
    assign own_match = r_pend && (i_rdata.addrs == r_fa) && (i_rdata.ports == r_fp);
    assign rev_match = r_pend && (i_rdata.addrs == rev_fa) && (i_rdata.ports == rev_fp);

    assign prod = $signed({1'b0, i_match_count}) * i_delta_per_match;

    assign room       = (r_count < FullCount);
    assign upd_active = (r_state == S_UPD) && r_tcp && r_mcnt_nz;

    always_comb begin
        n_seq     = r_seq;
        n_ack     = r_ack;
        n_len     = r_len;
        n_changed = 1'b0;
        if (r_tcp) begin
            if (r_own_hit && (r_own_delta != 32'd0)) begin
                n_seq     = r_seq + r_own_delta;
                n_changed = 1'b1;
            end
            if (r_rev_hit && (r_rev_delta != 32'd0)) begin
                n_ack     = r_ack + r_rev_delta;
                n_changed = 1'b1;
            end
            if (r_mcnt_nz) begin
                n_len     = r_len + r_add[15:0];
                n_changed = 1'b1;
            end
        end
    end

    always_comb begin
        o_wr.we         = upd_active && (r_own_hit || room);
        o_wr.data.addrs = r_fa;
        o_wr.data.ports = r_fp;
        o_wr.data.delta = r_own_hit ? (r_own_delta + r_add) : r_add;
        o_waddr         = r_own_hit ? r_own_idx : r_count[IdxW-1:0];
    end

    assign o_raddr = r_addr[IdxW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_fa      <= {i_src_addr, i_dst_addr};
                        r_fp      <= {i_src_port, i_dst_port, i_protocol};
                        r_seq     <= i_seq_num;
                        r_ack     <= i_ack_num;
                        r_len     <= i_ip_total_length;
                        r_mcnt_nz <= (i_match_count != '0);
                        r_tcp     <= (i_protocol == PROTO_TCP);
                        r_add     <= {{8{prod[23]}}, prod};
                        r_addr    <= '0;
                        r_pend    <= 1'b0;
                        r_own_hit <= 1'b0;
                        r_rev_hit <= 1'b0;
                        r_state   <= (i_protocol == PROTO_TCP) ? S_WALK : S_UPD;
                    end
                end
                S_WALK: begin
                    if (own_match) begin
                        r_own_hit   <= 1'b1;
                        r_own_idx   <= r_pend_idx;
                        r_own_delta <= i_rdata.delta;
                    end
                    if (rev_match) begin
                        r_rev_hit   <= 1'b1;
                        r_rev_delta <= i_rdata.delta;
                    end
                    if (r_addr < r_count) begin
                        r_pend     <= 1'b1;
                        r_pend_idx <= r_addr[IdxW-1:0];
                        r_addr     <= r_addr + 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_state <= S_UPD;
                        end
                    end
                end
                S_UPD: begin
                    if (upd_active && !r_own_hit && room) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_new_seq <= n_seq;
                    r_new_ack <= n_ack;
                    r_new_len <= n_len;
                    r_changed <= n_changed;
                    r_full    <= upd_active && !r_own_hit && !room;
                    r_valid   <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_valid;
    assign o_new_seq_num    = r_new_seq;
    assign o_new_ack_num    = r_new_ack;
    assign o_new_ip_length  = r_new_len;
    assign o_header_changed = r_changed;
    assign o_table_full     = r_full;

    `TSAF_ASSERT_NEXT(a_upd_gives_result, r_state == S_UPD, r_valid && (r_state == S_IDLE), "update did not yield exactly one result")
    `TSAF_ASSERT_SAME(a_count_bound, 1'b1, r_count <= FullCount, "flow count exceeds table size")
    `TSAF_ASSERT_SAME(a_full_only_when_full, r_valid && r_full, r_count == FullCount, "table full reported with free slots")
    `TSAF_ASSERT_SAME(a_write_only_in_update, o_wr.we, r_state == S_UPD, "table written outside the update step")

endmodule

@@ sv/tcp_seq_ack_flow_adjust_unit.sv @@
// Top level of the TCP sequence and acknowledgement flow adjustment unit.
// Holds the per-match delta register; instantiates tsaf_engine and tsaf_flow_mem.
// Depends on tsaf_pkg.
//
//  Channel   Handshake                     Payload
//  ------    ---------                     -------
//  header    start / busy                  i_src_addr .. i_match_count
//  result    o_valid (one-cycle strobe)    o_new_seq_num .. o_table_full
//  config    i_cfg_valid / o_cfg_ready     i_cfg_data
//
// A TCP header keeps the unit busy from acceptance through the walk over the
// filled table, at one entry per cycle through the single read port, and then
// through the update step; other headers go straight to the update step.
// Reset is synchronous and active low, and leaves the flow table empty.
// The result strobe lasts one cycle and the receiver cannot stall it.
module tcp_seq_ack_flow_adjust_unit
    import tsaf_pkg::*;
#(
    parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [31:0]             i_src_addr,
    input  logic [15:0]             i_src_port,
    input  logic [31:0]             i_dst_addr,
    input  logic [15:0]             i_dst_port,
    input  logic [7:0]              i_protocol,
    input  logic [31:0]             i_seq_num,
    input  logic [31:0]             i_ack_num,
    input  logic [15:0]             i_ip_total_length,
    input  logic [MCNT_W-1:0]       i_match_count,
    output logic                    o_valid,
    output logic [31:0]             o_new_seq_num,
    output logic [31:0]             o_new_ack_num,
    output logic [15:0]             o_new_ip_length,
    output logic                    o_header_changed,
    output logic                    o_table_full,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic signed [DPM_W-1:0] i_cfg_data
);

    localparam int IdxW = $clog2(FLOW_ENTRIES);

    logic signed [DPM_W-1:0] r_delta_per_match;
    logic [IdxW-1:0]         raddr;
    logic [IdxW-1:0]         waddr;
    t_flow_entry             rdata;
    t_mem_wr                 wr;

    assign o_cfg_ready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta_per_match <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_delta_per_match <= i_cfg_data;
        end
    end

    tsaf_engine #(
        .FLOW_ENTRIES (FLOW_ENTRIES)
    ) u_engine (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_src_addr        (i_src_addr),
        .i_src_port        (i_src_port),
        .i_dst_addr        (i_dst_addr),
        .i_dst_port        (i_dst_port),
        .i_protocol        (i_protocol),
        .i_seq_num         (i_seq_num),
        .i_ack_num         (i_ack_num),
        .i_ip_total_length (i_ip_total_length),
        .i_match_count     (i_match_count),
        .i_delta_per_match (r_delta_per_match),
        .o_valid           (o_valid),
        .o_new_seq_num     (o_new_seq_num),
        .o_new_ack_num     (o_new_ack_num),
        .o_new_ip_length   (o_new_ip_length),
        .o_header_changed  (o_header_changed),
        .o_table_full      (o_table_full),
        .o_raddr           (raddr),
        .i_rdata           (rdata),
        .o_wr              (wr),
        .o_waddr           (waddr)
    );

    tsaf_flow_mem #(
        .FLOW_ENTRIES (FLOW_ENTRIES)
    ) u_flow_mem (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_waddr (waddr),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule
